// ===== hw/rtl/circular_fifo_one_slot_empty_top_assert.svh =====
// Assertion macros for the ring-buffer FIFO.
// Included by the top level; synthesis builds see empty bodies.
`ifndef CIRCULAR_FIFO_ONE_SLOT_EMPTY_TOP_ASSERT_SVH
`define CIRCULAR_FIFO_ONE_SLOT_EMPTY_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define CFOSE_ASSERT_IMPL(label, clk, rst_n, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);
// Next-cycle implication, disabled during reset.
`define CFOSE_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`else
`define CFOSE_ASSERT_IMPL(label, clk, rst_n, a, b, msg)
`define CFOSE_ASSERT_NEXT(label, clk, rst_n, a, b, msg)
`endif
`endif

// ===== hw/rtl/cfose_pkg.sv =====
// Shared types and constants of the ring-buffer FIFO.
// No dependencies; used by every module of the block.
package cfose_pkg;

  localparam int DEF_MAX_SLOTS = 64;
  localparam int CFG_W         = 7;
  localparam int WORD_W        = 64;
  localparam int ITEM_W        = 2 * WORD_W;
  localparam int FREE_W        = 6;
  localparam int OP_W          = 2;
  localparam int OUT_TDATA_W   = 136;

  // Operation codes carried in the input tuser.
  localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OP_W-1:0] OP_GET   = 2'd1;
  localparam logic [OP_W-1:0] OP_DRAIN = 2'd2;

  // Memory access strobes from the controller.
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_cmd_t;

  // One result item.
  typedef struct packed {
    logic              success;
    logic [WORD_W-1:0] data_real;
    logic [WORD_W-1:0] data_imag;
    logic [FREE_W-1:0] free_slots;
    logic              last;
  } result_t;

endpackage

// ===== hw/rtl/cfose_mem.sv =====
// Sample store of the ring-buffer FIFO: one write port, one registered read port.
// Depends on cfose_pkg.
module cfose_mem #(
  parameter int MAX_SLOTS = cfose_pkg::DEF_MAX_SLOTS,
  parameter int PTR_W     = $clog2(MAX_SLOTS)
) (
  input  logic                      clk,
  input  cfose_pkg::mem_cmd_t       cmd,
  input  logic [PTR_W-1:0]          wr_addr,
  input  logic [cfose_pkg::ITEM_W-1:0] wr_data,
  input  logic [PTR_W-1:0]          rd_addr,
  output logic [cfose_pkg::ITEM_W-1:0] rd_data
);
  import cfose_pkg::*;

  logic [ITEM_W-1:0] mem [MAX_SLOTS];
  logic [ITEM_W-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/cfose_ctrl.sv =====
// Controller of the ring-buffer FIFO: pointers, occupancy, length and result register.
// Depends on cfose_pkg; drives the cfose_mem store.
module cfose_ctrl #(
  parameter int MAX_SLOTS = cfose_pkg::DEF_MAX_SLOTS,
  parameter int PTR_W     = $clog2(MAX_SLOTS),
  parameter int LEN_W     = $clog2(MAX_SLOTS + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [cfose_pkg::OP_W-1:0]   in_op,
  input  logic                         cfg_wr_en,
  input  logic [cfose_pkg::CFG_W-1:0]  cfg_wr_data,
  output cfose_pkg::mem_cmd_t          mem_cmd,
  output logic [PTR_W-1:0]             wr_addr,
  output logic [PTR_W-1:0]             rd_addr,
  input  logic [cfose_pkg::ITEM_W-1:0] rd_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output cfose_pkg::result_t           out_res
);
  import cfose_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_FETCH = 3'b010,
    S_NEXT  = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  logic [PTR_W-1:0] wptr_r, wptr_nxt;
  logic [PTR_W-1:0] rptr_r, rptr_nxt;
  logic [PTR_W-1:0] occ_r, occ_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic             drain_r, drain_nxt;
  logic             out_valid_r, out_valid_nxt;
  result_t          res_r, res_nxt;

  logic out_free, accept, empty, full, load;

  // Pointer step that wraps at the configured length.
  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p,
                                               input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] n;
    n = LEN_W'(p) + LEN_W'(1);
    if (n >= len) begin
      return '0;
    end
    return n[PTR_W-1:0];
  endfunction

  // Free slots for a given occupancy.
  function automatic logic [FREE_W-1:0] free_of(input logic [PTR_W-1:0] occ,
                                                input logic [LEN_W-1:0] len);
    logic [CFG_W-1:0] f;
    f = CFG_W'(len) - CFG_W'(1) - CFG_W'(occ);
    return f[FREE_W-1:0];
  endfunction

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE) && out_free;
  assign accept   = in_valid && in_ready;
  assign empty    = (occ_r == '0);
  assign full     = ((LEN_W'(occ_r) + LEN_W'(1)) == len_r);
  assign wr_addr  = wptr_r;
  assign rd_addr  = rptr_r;

  // Sequencing of puts, gets and drains.
  always_comb begin
    state_nxt     = state_r;
    wptr_nxt      = wptr_r;
    rptr_nxt      = rptr_r;
    occ_nxt       = occ_r;
    len_nxt       = len_r;
    drain_nxt     = drain_r;
    res_nxt       = res_r;
    load          = 1'b0;
    mem_cmd.wr_en = 1'b0;
    mem_cmd.rd_en = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_op == OP_PUT) begin
            load               = 1'b1;
            res_nxt.data_real  = '0;
            res_nxt.data_imag  = '0;
            res_nxt.last       = 1'b1;
            res_nxt.success    = !full;
            res_nxt.free_slots = free_of(occ_r, len_r);
            if (!full) begin
              mem_cmd.wr_en      = 1'b1;
              wptr_nxt           = advance(wptr_r, len_r);
              occ_nxt            = occ_r + PTR_W'(1);
              res_nxt.free_slots = free_of(occ_r + PTR_W'(1), len_r);
            end
          end else if ((in_op == OP_GET || in_op == OP_DRAIN) && !empty) begin
            mem_cmd.rd_en = 1'b1;
            rptr_nxt      = advance(rptr_r, len_r);
            occ_nxt       = occ_r - PTR_W'(1);
            drain_nxt     = (in_op == OP_DRAIN);
            state_nxt     = S_FETCH;
          end else begin
            // Get or drain of an empty buffer, or an unused code.
            load               = 1'b1;
            res_nxt.success    = 1'b0;
            res_nxt.data_real  = '0;
            res_nxt.data_imag  = '0;
            res_nxt.free_slots = free_of(occ_r, len_r);
            res_nxt.last       = 1'b1;
          end
        end else if (cfg_wr_en && empty) begin
          // A length change is taken only while empty and rewinds both pointers.
          wptr_nxt = '0;
          rptr_nxt = '0;
          if (cfg_wr_data < CFG_W'(2)) begin
            len_nxt = LEN_W'(2);
          end else if (cfg_wr_data > CFG_W'(MAX_SLOTS)) begin
            len_nxt = LEN_W'(MAX_SLOTS);
          end else begin
            len_nxt = cfg_wr_data[LEN_W-1:0];
          end
        end
      end
      S_FETCH: begin
        // Read data has arrived; the result register is free here.
        load               = 1'b1;
        res_nxt.success    = 1'b1;
        res_nxt.data_real  = rd_data[WORD_W-1:0];
        res_nxt.data_imag  = rd_data[ITEM_W-1:WORD_W];
        res_nxt.free_slots = free_of(occ_r, len_r);
        res_nxt.last       = !drain_r || empty;
        state_nxt          = (!drain_r || empty) ? S_IDLE : S_NEXT;
      end
      S_NEXT: begin
        // Next drain read once the result register can take it.
        if (out_free) begin
          mem_cmd.rd_en = 1'b1;
          rptr_nxt      = advance(rptr_r, len_r);
          occ_nxt       = occ_r - PTR_W'(1);
          state_nxt     = S_FETCH;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Result register handshake.
  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wptr_r      <= '0;
      rptr_r      <= '0;
      occ_r       <= '0;
      len_r       <= LEN_W'(MAX_SLOTS);
      drain_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wptr_r      <= wptr_nxt;
      rptr_r      <= rptr_nxt;
      occ_r       <= occ_nxt;
      len_r       <= len_nxt;
      drain_r     <= drain_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

endmodule

// ===== hw/rtl/circular_fifo_one_slot_empty_top.sv =====
// Ring-buffer FIFO of complex samples, one slot kept empty.
// Put and failed operations: result registered in the cycle after acceptance, one item
// a cycle while results are taken. Get and drain: the store's read register, then the
// result register. Input waits for each get; drain reads wait for a free result register.
// A result held by a stalled receiver blocks the input until it is taken.
// Synchronous active-low reset: pointers and occupancy zero, length MAX_SLOTS.
module circular_fifo_one_slot_empty_top #(
  parameter int MAX_SLOTS = cfose_pkg::DEF_MAX_SLOTS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [63:0] elem_real, [127:64] elem_imag
  input  logic [cfose_pkg::ITEM_W-1:0]        in_tdata,
  // [1:0] opcode
  input  logic [cfose_pkg::OP_W-1:0]          in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [63:0] data_real, [127:64] data_imag, [133:128] free_slots, [135:134] zero
  output logic [cfose_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // [0] success
  output logic                                out_tuser,
  output logic                                out_tlast,
  input  logic                                cfg_wr_en,
  input  logic [cfose_pkg::CFG_W-1:0]         cfg_wr_data
);
  import cfose_pkg::*;

  `include "circular_fifo_one_slot_empty_top_assert.svh"

  localparam int PTR_W = $clog2(MAX_SLOTS);
  localparam int LEN_W = $clog2(MAX_SLOTS + 1);

  mem_cmd_t          mem_cmd;
  logic [PTR_W-1:0]  wr_addr, rd_addr;
  logic [ITEM_W-1:0] rd_data;
  result_t           res;
  logic              drain_step;

  cfose_ctrl #(
    .MAX_SLOTS(MAX_SLOTS),
    .PTR_W    (PTR_W),
    .LEN_W    (LEN_W)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_op      (in_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .mem_cmd    (mem_cmd),
    .wr_addr    (wr_addr),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_res    (res)
  );

  cfose_mem #(
    .MAX_SLOTS(MAX_SLOTS),
    .PTR_W    (PTR_W)
  ) u_mem (
    .clk    (clk),
    .cmd    (mem_cmd),
    .wr_addr(wr_addr),
    .wr_data(in_tdata),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // Pack the result item onto the output stream.
  assign out_tdata = {{(OUT_TDATA_W - ITEM_W - FREE_W){1'b0}},
                      res.free_slots, res.data_imag, res.data_real};
  assign out_tuser = res.success;
  assign out_tlast = res.last;

  // A non-final drain result is being taken.
  assign drain_step = out_tvalid && out_tready && !out_tlast;

  // A held result blocks new input items.
  `CFOSE_ASSERT_IMPL(a_stall, clk, rst_n, out_tvalid && !out_tready, !in_tready, "input in stall")
  // A failed operation always ends its run.
  `CFOSE_ASSERT_IMPL(a_fail_last, clk, rst_n, out_tvalid && !out_tuser, out_tlast, "fail not last")
  // Only successful drain results may be followed by more.
  `CFOSE_ASSERT_IMPL(a_more_ok, clk, rst_n, out_tvalid && !out_tlast, out_tuser, "failed mid-run")
  // While a drain continues no new item is taken.
  `CFOSE_ASSERT_NEXT(a_drain_hold, clk, rst_n, drain_step, !in_tready, "input taken in a drain")

endmodule
